### rtl/core/rpvn_pkg.sv
`timescale 1ns / 1ps
package rpvn_pkg;

   localparam int MAX_SIDES        = 64;
   localparam int NORMAL_FRAC_BITS = 14;

   localparam int IDX_W      = 6;
   localparam int SIDE_W     = 7;
   localparam int RADIUS_W   = 16;
   localparam int POS_W      = 17;
   localparam int NRM_W      = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIDES  = 1'b1;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd256;
   localparam logic [SIDE_W-1:0]   SIDES_RESET  = 7'd4;

   localparam int PHASE_BITS   = 20;
   localparam int CORDIC_STEPS = 18;
   localparam int TRIG_W       = 32;
   localparam int ANG_W        = PHASE_BITS + 1;
   localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;

   localparam logic signed [ANG_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
      21'sd131072, 21'sd77376, 21'sd40884, 21'sd20753, 21'sd10417, 21'sd5213,
      21'sd2607, 21'sd1304, 21'sd652, 21'sd326, 21'sd163, 21'sd81,
      21'sd41, 21'sd20, 21'sd10, 21'sd5, 21'sd3, 21'sd1
   };

   localparam int MAG_W      = 18;
   localparam int K_W        = 5;
   localparam int SQ_W       = 62;
   localparam int ROOT_STEPS = 31;
   localparam int LEN_W      = 31;
   localparam int DIV_W      = 47;
   localparam int QUO_W      = 16;

   typedef struct packed {
      logic                    err;
      logic                    zero;
      logic signed [POS_W-1:0] px;
      logic signed [POS_W-1:0] py;
      logic                    sgn_x;
      logic                    sgn_y;
      logic [MAG_W-1:0]        mag_x;
      logic [MAG_W-1:0]        mag_y;
      logic [K_W-1:0]          k;
   } tag_type;

endpackage

### rtl/core/rpvn_cordic.sv
`timescale 1ns / 1ps
module rpvn_cordic (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic [rpvn_pkg::PHASE_BITS-1:0]      phase [2],
   input  rpvn_pkg::tag_type                    tag_in,
   output logic                                 out_valid,
   output logic signed [rpvn_pkg::TRIG_W-1:0]   cos_q [2],
   output logic signed [rpvn_pkg::TRIG_W-1:0]   sin_q [2],
   output rpvn_pkg::tag_type                    tag_out
);
   import rpvn_pkg::*;

   localparam logic [PHASE_BITS-1:0] QTR = PHASE_BITS'(1) << (PHASE_BITS - 2);

   logic signed [TRIG_W-1:0] x_ff [CORDIC_STEPS+1][2];
   logic signed [TRIG_W-1:0] y_ff [CORDIC_STEPS+1][2];
   logic signed [ANG_W-1:0]  z_ff [CORDIC_STEPS+1][2];
   logic                     neg_ff [CORDIC_STEPS+1][2];
   logic                     vld_ff [CORDIC_STEPS+1];
   tag_type                  tag_ff [CORDIC_STEPS+1];

   logic signed [TRIG_W-1:0] cos_ff [2];
   logic signed [TRIG_W-1:0] sin_ff [2];
   logic                     out_vld_ff;
   tag_type                  out_tag_ff;

   // Fold the phase into the right half plane; the left half is a negated result.
   for (genvar l = 0; l < 2; l++) begin : g_fold
      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[0][l] <= CORDIC_GAIN;
            y_ff[0][l] <= '0;
            if (phase[l] >= QTR && phase[l] < 3 * QTR) begin
               z_ff[0][l]   <= $signed({1'b0, phase[l]}) - $signed(ANG_W'(2 * QTR));
               neg_ff[0][l] <= 1'b1;
            end else if (phase[l] >= 3 * QTR) begin
               z_ff[0][l]   <= $signed({1'b0, phase[l]}) - $signed(ANG_W'(4 * QTR));
               neg_ff[0][l] <= 1'b0;
            end else begin
               z_ff[0][l]   <= $signed({1'b0, phase[l]});
               neg_ff[0][l] <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0] <= tag_in;
      end
   end

   for (genvar s = 1; s <= CORDIC_STEPS; s++) begin : g_step
      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic signed [TRIG_W-1:0] dx;
         logic signed [TRIG_W-1:0] dy;
         assign dx = y_ff[s-1][l] >>> (s - 1);
         assign dy = x_ff[s-1][l] >>> (s - 1);
         always_ff @(posedge clock) begin
            if (en) begin
               neg_ff[s][l] <= neg_ff[s-1][l];
               if (z_ff[s-1][l] >= 0) begin
                  x_ff[s][l] <= x_ff[s-1][l] - dx;
                  y_ff[s][l] <= y_ff[s-1][l] + dy;
                  z_ff[s][l] <= z_ff[s-1][l] - ATAN_TURNS[s-1];
               end else begin
                  x_ff[s][l] <= x_ff[s-1][l] + dx;
                  y_ff[s][l] <= y_ff[s-1][l] - dy;
                  z_ff[s][l] <= z_ff[s-1][l] + ATAN_TURNS[s-1];
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            tag_ff[s] <= tag_ff[s-1];
         end
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_out
      always_ff @(posedge clock) begin
         if (en) begin
            cos_ff[l] <= neg_ff[CORDIC_STEPS][l] ? -x_ff[CORDIC_STEPS][l] : x_ff[CORDIC_STEPS][l];
            sin_ff[l] <= neg_ff[CORDIC_STEPS][l] ? -y_ff[CORDIC_STEPS][l] : y_ff[CORDIC_STEPS][l];
         end
      end
      assign cos_q[l] = cos_ff[l];
      assign sin_q[l] = sin_ff[l];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= vld_ff[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_tag_ff <= tag_ff[CORDIC_STEPS];
      end
   end

   assign out_valid = out_vld_ff;
   assign tag_out   = out_tag_ff;

endmodule

### rtl/core/rpvn_sqrt.sv
`timescale 1ns / 1ps
module rpvn_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [rpvn_pkg::SQ_W-1:0]     value,
   input  rpvn_pkg::tag_type             tag_in,
   output logic                          out_valid,
   output logic [rpvn_pkg::LEN_W-1:0]    root,
   output rpvn_pkg::tag_type             tag_out
);
   import rpvn_pkg::*;

   logic [SQ_W-1:0] rem_q  [ROOT_STEPS+1];
   logic [SQ_W-1:0] root_q [ROOT_STEPS+1];
   logic            vld_q  [ROOT_STEPS+1];
   tag_type         tag_q  [ROOT_STEPS+1];

   logic [SQ_W-1:0] rem_ff  [ROOT_STEPS];
   logic [SQ_W-1:0] root_ff [ROOT_STEPS];
   logic            vld_ff  [ROOT_STEPS];
   tag_type         tag_ff  [ROOT_STEPS];

   assign rem_q[0]  = value;
   assign root_q[0] = '0;
   assign vld_q[0]  = in_valid;
   assign tag_q[0]  = tag_in;

   // One result bit per stage; the input is already scaled into the top quarter.
   for (genvar s = 0; s < ROOT_STEPS; s++) begin : g_step
      localparam logic [SQ_W:0] BIT = (SQ_W + 1)'(1) << (SQ_W - 2 - 2 * s);
      logic [SQ_W:0] trial;
      assign trial = {1'b0, root_q[s]} + BIT;

      always_ff @(posedge clock) begin
         if (en) begin
            tag_ff[s] <= tag_q[s];
            if ({1'b0, rem_q[s]} >= trial) begin
               rem_ff[s]  <= SQ_W'({1'b0, rem_q[s]} - trial);
               root_ff[s] <= SQ_W'({1'b0, root_q[s] >> 1} + BIT);
            end else begin
               rem_ff[s]  <= rem_q[s];
               root_ff[s] <= root_q[s] >> 1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_q[s];
         end
      end

      assign rem_q[s+1]  = rem_ff[s];
      assign root_q[s+1] = root_ff[s];
      assign vld_q[s+1]  = vld_ff[s];
      assign tag_q[s+1]  = tag_ff[s];
   end

   assign out_valid = vld_q[ROOT_STEPS];
   assign root      = root_q[ROOT_STEPS][LEN_W-1:0];
   assign tag_out   = tag_q[ROOT_STEPS];

endmodule

### rtl/core/rpvn_div.sv
`timescale 1ns / 1ps
module rpvn_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [rpvn_pkg::DIV_W-1:0]    num [2],
   input  logic [rpvn_pkg::LEN_W-1:0]    den,
   input  rpvn_pkg::tag_type             tag_in,
   output logic                          out_valid,
   output logic [rpvn_pkg::QUO_W-1:0]    quo [2],
   output rpvn_pkg::tag_type             tag_out
);
   import rpvn_pkg::*;

   logic [DIV_W-1:0] rem_q [QUO_W+1][2];
   logic [QUO_W-1:0] quo_q [QUO_W+1][2];
   logic [LEN_W-1:0] den_q [QUO_W+1];
   logic             vld_q [QUO_W+1];
   tag_type          tag_q [QUO_W+1];

   logic [DIV_W-1:0] rem_ff [QUO_W][2];
   logic [QUO_W-1:0] quo_ff [QUO_W][2];
   logic [LEN_W-1:0] den_ff [QUO_W];
   logic             vld_ff [QUO_W];
   tag_type          tag_ff [QUO_W];

   for (genvar l = 0; l < 2; l++) begin : g_in
      assign rem_q[0][l] = num[l];
      assign quo_q[0][l] = '0;
   end
   assign den_q[0] = den;
   assign vld_q[0] = in_valid;
   assign tag_q[0] = tag_in;

   // Restoring division, most significant quotient bit first. The numerator
   // stays below den times two to the quotient width, so no bit is lost.
   for (genvar s = 0; s < QUO_W; s++) begin : g_step
      localparam int J = QUO_W - 1 - s;
      logic [DIV_W-1:0] dsh;
      assign dsh = DIV_W'(den_q[s]) << J;

      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic take;
         assign take = rem_q[s][l] >= dsh;
         always_ff @(posedge clock) begin
            if (en) begin
               quo_ff[s][l] <= quo_q[s][l] | (take ? (QUO_W'(1) << J) : '0);
               rem_ff[s][l] <= take ? rem_q[s][l] - dsh : rem_q[s][l];
            end
         end
         assign rem_q[s+1][l] = rem_ff[s][l];
         assign quo_q[s+1][l] = quo_ff[s][l];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[s] <= den_q[s];
            tag_ff[s] <= tag_q[s];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_q[s];
         end
      end

      assign den_q[s+1] = den_ff[s];
      assign vld_q[s+1] = vld_ff[s];
      assign tag_q[s+1] = tag_ff[s];
   end

   for (genvar l = 0; l < 2; l++) begin : g_out
      assign quo[l] = quo_q[QUO_W][l];
   end
   assign out_valid = vld_q[QUO_W];
   assign tag_out   = tag_q[QUO_W];

endmodule

### rtl/core/regular_polygon_vertex_normal.sv
`timescale 1ns / 1ps
// Vertex and outward face normal of a regular polygon centered on the origin. Each vertex
// index word yields one result word; the block takes a new word in every cycle unless a
// stalled result holds it. Its stages are those of the CORDIC (20), the bit-per-stage
// square root (31) and the bit-per-stage normal divider (16) plus eleven stages of scaling,
// face and normalization logic. A stalled result holds the whole pipeline, so the input
// stall follows the output stall in the same cycle. Radius is Q8.8, positions are Q8.8
// saturated to +-65535, normals carry 14 fraction bits; an index at or beyond the side count
// gives all zero fields with the error flag set. The user writes registers through the csr
// port (index 0 radius, index 1 side count) only while no word is in flight (not enforced).
module regular_polygon_vertex_normal (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [rpvn_pkg::IDX_W-1:0]           req_vertex_index,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [rpvn_pkg::POS_W-1:0]    rsp_pos_x,
   output logic signed [rpvn_pkg::POS_W-1:0]    rsp_pos_y,
   output logic signed [rpvn_pkg::NRM_W-1:0]    rsp_normal_x,
   output logic signed [rpvn_pkg::NRM_W-1:0]    rsp_normal_y,
   output logic                                 rsp_index_error,
   input  logic                                 csr_write,
   input  logic [rpvn_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rpvn_pkg::CSR_DATA_W-1:0]      csr_data
);
   import rpvn_pkg::*;

   localparam int RECIP_SHIFT = PHASE_BITS + 13;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int PROD_W      = RECIP_W + IDX_W;
   localparam int SCL_W       = TRIG_W + RADIUS_W + 1;
   localparam int DIF_W       = POS_W + 1;
   localparam int SQR_W       = 2 * DIF_W;
   localparam int NORM_TOP    = SQ_W - 2;
   localparam int POS_MAX     = 65535;
   localparam logic [QUO_W-1:0] NRM_LIM = QUO_W'(1) << NORMAL_FRAC_BITS;

   logic en;

   logic [RADIUS_W-1:0] radius_ff;
   logic [SIDE_W-1:0]   sides_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
         sides_ff  <= SIDES_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_RADIUS: radius_ff <= csr_data[RADIUS_W-1:0];
            CSR_SIDES:  sides_ff  <= csr_data[SIDE_W-1:0];
            default:    ;
         endcase
      end
   end

   // Reciprocals ceil(2^RECIP_SHIFT / n); rounding up keeps the phase exact.
   logic [RECIP_W-1:0] recip_tab [MAX_SIDES+1];
   assign recip_tab[0] = '0;
   for (genvar g = 1; g <= MAX_SIDES; g++) begin : g_recip
      localparam logic [RECIP_W-1:0] RECIP =
         RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(g) - 64'd1) / 64'(g));
      assign recip_tab[g] = RECIP;
   end

   logic rsp_valid_ff;
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // Stage 1: index checks and reciprocal lookup.
   logic [SIDE_W-1:0] n_eff, idx_ext, idx_inc;
   logic              err_in;
   assign n_eff   = (sides_ff > SIDE_W'(MAX_SIDES)) ? SIDE_W'(MAX_SIDES) : sides_ff;
   assign idx_ext = {1'b0, req_vertex_index};
   assign idx_inc = idx_ext + SIDE_W'(1);
   assign err_in  = (n_eff == '0) || (idx_ext >= n_eff);

   logic               s1_valid_ff, s1_err_ff;
   logic [IDX_W-1:0]   s1_idx_ff [2];
   logic [RECIP_W-1:0] s1_recip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_err_ff    <= err_in;
         s1_idx_ff[0] <= req_vertex_index;
         s1_idx_ff[1] <= (idx_inc < n_eff) ? idx_inc[IDX_W-1:0] : '0;
         s1_recip_ff  <= recip_tab[n_eff];
      end
   end

   // Stage 2: phase products.
   logic              s2_valid_ff, s2_err_ff;
   logic [PROD_W-1:0] s2_prod_ff [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_err_ff     <= s1_err_ff;
         s2_prod_ff[0] <= PROD_W'(s1_idx_ff[0]) * PROD_W'(s1_recip_ff);
         s2_prod_ff[1] <= PROD_W'(s1_idx_ff[1]) * PROD_W'(s1_recip_ff);
      end
   end

   logic [PHASE_BITS-1:0] phase [2];
   logic [PROD_W-1:0]     phase_sum [2];
   for (genvar l = 0; l < 2; l++) begin : g_phase
      assign phase_sum[l] = s2_prod_ff[l] + (PROD_W'(1) << (RECIP_SHIFT - PHASE_BITS - 1));
      assign phase[l]     = phase_sum[l][RECIP_SHIFT-1 -: PHASE_BITS];
   end

   tag_type tag_c;
   always_comb begin
      tag_c     = '0;
      tag_c.err = s2_err_ff;
   end

   logic                     c_valid;
   logic signed [TRIG_W-1:0] c_cos [2];
   logic signed [TRIG_W-1:0] c_sin [2];
   tag_type                  c_tag;

   rpvn_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s2_valid_ff),
      .phase     (phase),
      .tag_in    (tag_c),
      .out_valid (c_valid),
      .cos_q     (c_cos),
      .sin_q     (c_sin),
      .tag_out   (c_tag)
   );

   // Stage 4: scale by the radius. Order is x0, y0, x1, y1.
   logic                    s4_valid_ff;
   logic signed [SCL_W-1:0] s4_prod_ff [4];
   tag_type                 s4_tag_ff;
   logic signed [TRIG_W-1:0] trig [4];
   logic signed [RADIUS_W:0] radius_s;

   assign trig[0]  = c_cos[0];
   assign trig[1]  = c_sin[0];
   assign trig[2]  = c_cos[1];
   assign trig[3]  = c_sin[1];
   assign radius_s = $signed({1'b0, radius_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= c_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_tag_ff <= c_tag;
         for (int i = 0; i < 4; i++) begin
            s4_prod_ff[i] <= trig[i] * radius_s;
         end
      end
   end

   function automatic logic signed [POS_W-1:0] round_sat(input logic signed [SCL_W-1:0] p);
      logic signed [SCL_W-1:0] v;
      v = (p + (SCL_W'(1) <<< (TRIG_W - 3))) >>> (TRIG_W - 2);
      if (v > $signed(SCL_W'(POS_MAX))) begin
         v = $signed(SCL_W'(POS_MAX));
      end else if (v < -$signed(SCL_W'(POS_MAX))) begin
         v = -$signed(SCL_W'(POS_MAX));
      end
      return v[POS_W-1:0];
   endfunction

   // Stage 5: rounding and saturation.
   logic                    s5_valid_ff;
   logic signed [POS_W-1:0] s5_pos_ff [4];
   tag_type                 s5_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_tag_ff <= s4_tag_ff;
         for (int i = 0; i < 4; i++) begin
            s5_pos_ff[i] <= round_sat(s4_prod_ff[i]);
         end
      end
   end

   // Stage 6: face vector.
   logic                    s6_valid_ff;
   logic signed [DIF_W-1:0] s6_fx_ff, s6_fy_ff;
   tag_type                 s6_tag_ff;
   tag_type                 tag6;

   always_comb begin
      tag6    = s5_tag_ff;
      tag6.px = s5_pos_ff[0];
      tag6.py = s5_pos_ff[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (en) begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_fx_ff  <= DIF_W'(s5_pos_ff[2]) - DIF_W'(s5_pos_ff[0]);
         s6_fy_ff  <= DIF_W'(s5_pos_ff[3]) - DIF_W'(s5_pos_ff[1]);
         s6_tag_ff <= tag6;
      end
   end

   // Stage 7: squares; the normal is (fy, -fx) before scaling.
   logic                    s7_valid_ff;
   logic [SQR_W-1:0]        s7_sqx_ff, s7_sqy_ff;
   tag_type                 s7_tag_ff;
   logic signed [SQR_W-1:0] sqx, sqy;
   tag_type                 tag7;

   assign sqx = s6_fx_ff * s6_fx_ff;
   assign sqy = s6_fy_ff * s6_fy_ff;

   always_comb begin
      tag7       = s6_tag_ff;
      tag7.sgn_x = s6_fy_ff < 0;
      tag7.mag_x = $unsigned(s6_fy_ff < 0 ? -s6_fy_ff : s6_fy_ff);
      tag7.sgn_y = s6_fx_ff > 0;
      tag7.mag_y = $unsigned(s6_fx_ff < 0 ? -s6_fx_ff : s6_fx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else if (en) begin
         s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s7_sqx_ff <= $unsigned(sqx);
         s7_sqy_ff <= $unsigned(sqy);
         s7_tag_ff <= tag7;
      end
   end

   // Stage 8: squared length.
   logic            s8_valid_ff;
   logic [SQ_W-1:0] s8_v_ff;
   tag_type         s8_tag_ff;
   logic [SQ_W-1:0] len2;
   tag_type         tag8;

   assign len2 = SQ_W'(s7_sqx_ff) + SQ_W'(s7_sqy_ff);

   always_comb begin
      tag8      = s7_tag_ff;
      tag8.zero = len2 == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff <= 1'b0;
      end else if (en) begin
         s8_valid_ff <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s8_v_ff   <= len2;
         s8_tag_ff <= tag8;
      end
   end

   // Stages 9 and 10: scale by powers of four until the top quarter is reached.
   // The binary search finds the shift count less one, then one more step follows.
   logic            s9_valid_ff;
   logic [SQ_W-1:0] s9_v_ff;
   logic [K_W-1:0]  s9_k_ff;
   tag_type         s9_tag_ff;
   logic [SQ_W-1:0] v9;
   logic [K_W-1:0]  k9;

   always_comb begin
      v9 = s8_v_ff;
      k9 = '0;
      if (v9 < (SQ_W'(1) << (NORM_TOP - 32))) begin
         v9 = v9 << 32;
         k9 = k9 + K_W'(16);
      end
      if (v9 < (SQ_W'(1) << (NORM_TOP - 16))) begin
         v9 = v9 << 16;
         k9 = k9 + K_W'(8);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_valid_ff <= 1'b0;
      end else if (en) begin
         s9_valid_ff <= s8_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s9_v_ff   <= v9;
         s9_k_ff   <= k9;
         s9_tag_ff <= s8_tag_ff;
      end
   end

   logic            s10_valid_ff;
   logic [SQ_W-1:0] s10_v_ff;
   tag_type         s10_tag_ff;
   logic [SQ_W-1:0] v10;
   logic [K_W-1:0]  k10;
   tag_type         tag10;

   always_comb begin
      v10 = s9_v_ff;
      k10 = s9_k_ff;
      if (v10 < (SQ_W'(1) << (NORM_TOP - 8))) begin
         v10 = v10 << 8;
         k10 = k10 + K_W'(4);
      end
      if (v10 < (SQ_W'(1) << (NORM_TOP - 4))) begin
         v10 = v10 << 4;
         k10 = k10 + K_W'(2);
      end
      if (v10 < (SQ_W'(1) << (NORM_TOP - 2))) begin
         v10 = v10 << 2;
         k10 = k10 + K_W'(1);
      end
      v10 = v10 << 2;
      k10 = k10 + K_W'(1);
   end

   always_comb begin
      tag10   = s9_tag_ff;
      tag10.k = k10;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s10_valid_ff <= 1'b0;
      end else if (en) begin
         s10_valid_ff <= s9_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s10_v_ff   <= v10;
         s10_tag_ff <= tag10;
      end
   end

   logic             q_valid;
   logic [LEN_W-1:0] q_root;
   tag_type          q_tag;

   rpvn_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s10_valid_ff),
      .value     (s10_v_ff),
      .tag_in    (s10_tag_ff),
      .out_valid (q_valid),
      .root      (q_root),
      .tag_out   (q_tag)
   );

   // Stage 11: dividends with the rounding half of the length folded in.
   logic             s11_valid_ff;
   logic [DIV_W-1:0] s11_num_ff [2];
   logic [LEN_W-1:0] s11_den_ff;
   tag_type          s11_tag_ff;
   logic [DIV_W-1:0] shx, shy;

   assign shx = DIV_W'(q_tag.mag_x) << q_tag.k;
   assign shy = DIV_W'(q_tag.mag_y) << q_tag.k;

   always_ff @(posedge clock) begin
      if (reset) begin
         s11_valid_ff <= 1'b0;
      end else if (en) begin
         s11_valid_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s11_num_ff[0] <= (shx << NORMAL_FRAC_BITS) + DIV_W'(q_root >> 1);
         s11_num_ff[1] <= (shy << NORMAL_FRAC_BITS) + DIV_W'(q_root >> 1);
         s11_den_ff    <= q_root;
         s11_tag_ff    <= q_tag;
      end
   end

   logic             d_valid;
   logic [QUO_W-1:0] d_quo [2];
   tag_type          d_tag;

   rpvn_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s11_valid_ff),
      .num       (s11_num_ff),
      .den       (s11_den_ff),
      .tag_in    (s11_tag_ff),
      .out_valid (d_valid),
      .quo       (d_quo),
      .tag_out   (d_tag)
   );

   function automatic logic [NRM_W-1:0] signed_norm(input logic [QUO_W-1:0] q,
                                                    input logic sgn);
      logic [QUO_W-1:0] m;
      m = (q > NRM_LIM) ? NRM_LIM : q;
      return sgn ? NRM_W'(-m) : NRM_W'(m);
   endfunction

   // Output register.
   logic signed [POS_W-1:0] pos_x_ff, pos_y_ff;
   logic signed [NRM_W-1:0] nrm_x_ff, nrm_y_ff;
   logic                    err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         err_ff   <= d_tag.err;
         pos_x_ff <= d_tag.err ? '0 : d_tag.px;
         pos_y_ff <= d_tag.err ? '0 : d_tag.py;
         if (d_tag.err || d_tag.zero) begin
            nrm_x_ff <= '0;
            nrm_y_ff <= '0;
         end else begin
            nrm_x_ff <= $signed(signed_norm(d_quo[0], d_tag.sgn_x));
            nrm_y_ff <= $signed(signed_norm(d_quo[1], d_tag.sgn_y));
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = pos_x_ff;
   assign rsp_pos_y       = pos_y_ff;
   assign rsp_normal_x    = nrm_x_ff;
   assign rsp_normal_y    = nrm_y_ff;
   assign rsp_index_error = err_ff;

endmodule

### rtl/core/rpvn_checker.sv
`timescale 1ns / 1ps
module rpvn_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic [rpvn_pkg::IDX_W-1:0]           req_vertex_index,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [rpvn_pkg::POS_W-1:0]    rsp_pos_x,
   input logic signed [rpvn_pkg::POS_W-1:0]    rsp_pos_y,
   input logic signed [rpvn_pkg::NRM_W-1:0]    rsp_normal_x,
   input logic signed [rpvn_pkg::NRM_W-1:0]    rsp_normal_y,
   input logic                                 rsp_index_error,
   input logic                                 csr_write,
   input logic [rpvn_pkg::CSR_IDX_W-1:0]       csr_index,
   input logic [rpvn_pkg::CSR_DATA_W-1:0]      csr_data
);
   import rpvn_pkg::*;

   localparam logic signed [NRM_W-1:0] LIM = NRM_W'(1) << NORMAL_FRAC_BITS;

   // The pipeline only holds its input back while a result word is stalled.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a stalled result word");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y)
         && $stable(rsp_normal_x) && $stable(rsp_normal_y) && $stable(rsp_index_error)))
      else $error("stalled result word changed");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_index_error) |-> (rsp_pos_x == 0 && rsp_pos_y == 0
         && rsp_normal_x == 0 && rsp_normal_y == 0))
      else $error("error word carries nonzero fields");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_normal_x <= LIM && rsp_normal_x >= -LIM
         && rsp_normal_y <= LIM && rsp_normal_y >= -LIM))
      else $error("normal component beyond one");

endmodule

bind regular_polygon_vertex_normal rpvn_checker u_rpvn_checker (.*);

### sim/regular_polygon_vertex_normal_tb.sv
`timescale 1ns / 1ps
module regular_polygon_vertex_normal_tb;
   import rpvn_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 100;

   typedef struct packed {
      logic signed [POS_W-1:0] px;
      logic signed [POS_W-1:0] py;
      logic signed [NRM_W-1:0] nx;
      logic signed [NRM_W-1:0] ny;
      logic                    err;
   } vertex_type;

   typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      logic [CSR_IDX_W-1:0] reg_sel;
      int unsigned        value;
      bit                 typed_in;
      vertex_type         result;
   } stim_row_type;

   localparam longint ATAN_STEP [18] = '{
      131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304, 652,
      326, 163, 81, 41, 20, 10, 5, 3, 1
   };

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [IDX_W-1:0]        req_vertex_index;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic signed [POS_W-1:0] rsp_pos_x;
   logic signed [POS_W-1:0] rsp_pos_y;
   logic signed [NRM_W-1:0] rsp_normal_x;
   logic signed [NRM_W-1:0] rsp_normal_y;
   logic                    rsp_index_error;
   logic                    csr_write;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_data;

   regular_polygon_vertex_normal i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_vertex_index(req_vertex_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y),
      .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
      .rsp_index_error(rsp_index_error),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // Shadow copy of the block's registers.
   logic [RADIUS_W-1:0] cur_radius;
   logic [SIDE_W-1:0]   cur_sides;

   vertex_type   pending_vertices[$];
   bit           typed_flags[$];
   vertex_type   typed_results[$];
   stim_row_type stim_rows[$];
   int        mismatches;
   int        words_in;
   int        words_out;
   int        error_words;
   int        send_idle;
   int        recv_idle;
   int        quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void cordic_turn(input longint unsigned phase,
                                       output longint c, output longint s);
      longint p, q, x, y, z, dx, dy;
      bit neg;
      p = longint'(phase & 64'hFFFFF);
      q = 64'sd1 <<< 18;
      neg = 1'b0;
      x = 64'sd652032874;
      y = 0;
      if (p >= q && p < 3 * q) begin
         p = p - 2 * q;
         neg = 1'b1;
      end else if (p >= 3 * q) begin
         p = p - 4 * q;
      end
      z = p;
      for (int i = 0; i < 18; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - ATAN_STEP[i];
         end else begin
            x = x + dx; y = y - dy; z = z + ATAN_STEP[i];
         end
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
   endfunction

   function automatic longint scale_by_radius(input longint t);
      longint v;
      v = (t * longint'({48'd0, cur_radius}) + (64'sd1 <<< 29)) >>> 30;
      if (v > 65535) v = 65535;
      if (v < -65535) v = -65535;
      return v;
   endfunction

   function automatic void corner_at(input longint unsigned idx, input longint unsigned n,
                                     output longint px, output longint py);
      longint unsigned phase;
      longint c, s;
      phase = ((idx << 21) + n) / (2 * n);
      cordic_turn(phase, c, s);
      px = scale_by_radius(c);
      py = scale_by_radius(s);
   endfunction

   function automatic longint unsigned floor_sqrt(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unit_component(input longint comp, input int k,
                                             input longint unsigned len);
      longint unsigned mag, qv;
      mag = longint'(comp < 0 ? -comp : comp) << k;
      qv = ((mag << NORMAL_FRAC_BITS) + len / 2) / len;
      if (qv > (64'd1 << NORMAL_FRAC_BITS)) qv = 64'd1 << NORMAL_FRAC_BITS;
      return comp < 0 ? -longint'(qv) : longint'(qv);
   endfunction

   function automatic vertex_type predict_vertex(input logic [IDX_W-1:0] index_in);
      vertex_type r;
      longint unsigned n, idx, len2, len;
      longint x0, y0, x1, y1, fx, fy, nx, ny;
      int k;
      r = '0;
      idx = index_in;
      n = (cur_sides > MAX_SIDES) ? MAX_SIDES : cur_sides;
      if (n == 0 || idx >= n) begin
         r.err = 1'b1;
         return r;
      end
      corner_at(idx, n, x0, y0);
      corner_at((idx + 1 < n) ? idx + 1 : 0, n, x1, y1);
      fx = x1 - x0;
      fy = y1 - y0;
      nx = 0;
      ny = 0;
      len2 = fx * fx + fy * fy;
      if (len2 != 0) begin
         k = 0;
         while (len2 < (64'd1 << 60)) begin
            len2 = len2 << 2;
            k++;
         end
         len = floor_sqrt(len2);
         nx = unit_component(fy, k, len);
         ny = unit_component(-fx, k, len);
      end
      r.px = x0[POS_W-1:0];
      r.py = y0[POS_W-1:0];
      r.nx = nx[NRM_W-1:0];
      r.ny = ny[NRM_W-1:0];
      return r;
   endfunction

   // Accepted words are predicted at the edge that accepts them; results are checked
   // in order against the oldest prediction.
   always @(posedge clock) begin
      vertex_type got, want;
      bit         typed;
      vertex_type typed_val;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_pos_x, rsp_pos_y, rsp_normal_x, rsp_normal_y, rsp_index_error};
            words_out++;
            if (got.err) error_words++;
            if (pending_vertices.size() == 0) begin
               if (mismatches < 10) $display("Unexpected result word: %p", got);
               mismatches++;
            end else begin
               want = pending_vertices.pop_front();
               if (got !== want) begin
                  if (mismatches < 10)
                     $display("Mismatch: expected %p, got %p", want, got);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            typed = 1'b0;
            typed_val = '0;
            if (typed_flags.size() != 0) begin
               typed = typed_flags.pop_front();
               typed_val = typed_results.pop_front();
            end
            want = predict_vertex(req_vertex_index);
            if (typed && want !== typed_val) begin
               if (mismatches < 10)
                  $display("Predictor disagrees with typed-in result %p vs %p",
                           typed_val, want);
               mismatches++;
            end
            pending_vertices.insert(pending_vertices.size(), typed ? typed_val : want);
            words_in++;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   task automatic send_vertex(input logic [IDX_W-1:0] idx, input bit typed,
                              input vertex_type val);
      int gap;
      if ($urandom_range(99) < send_idle) begin
         gap = $urandom_range(1, 3);
         @(negedge clock);
         req_valid <= 1'b0;
         req_vertex_index <= IDX_W'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
      typed_flags.insert(typed_flags.size(), typed);
      typed_results.insert(typed_results.size(), val);
      @(negedge clock);
      req_valid <= 1'b1;
      req_vertex_index <= idx;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] sel, input int unsigned value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_vertices.size() != 0) @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= sel;
      csr_data <= CSR_DATA_W'(value);
      if (sel == CSR_RADIUS) cur_radius = RADIUS_W'(value);
      else cur_sides = SIDE_W'(value);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic void add_cfg(input logic [CSR_IDX_W-1:0] sel, input int unsigned value);
      stim_row_type row;
      row = '{ROW_CFG, sel, value, 1'b0, '0};
      stim_rows.insert(stim_rows.size(), row);
   endfunction

   function automatic void add_item(input int unsigned idx, input bit err_row);
      vertex_type e;
      stim_row_type row;
      e = '0;
      e.err = 1'b1;
      row = '{ROW_ITEM, CSR_RADIUS, idx, err_row, e};
      stim_rows.insert(stim_rows.size(), row);
   endfunction

   initial begin
      int unsigned radii[10];
      int unsigned sides[10];
      int n;
      int unsigned idx;
      reset = 1'b1;
      req_valid = 1'b0;
      req_vertex_index = '0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = CSR_RADIUS;
      csr_data = '0;
      cur_radius = RADIUS_RESET;
      cur_sides = SIDES_RESET;
      mismatches = 0;
      words_in = 0;
      words_out = 0;
      error_words = 0;
      send_idle = 36;
      recv_idle = 77;

      // Directed rows: reset setting, the radius and side count extremes, a single
      // vertex (degenerate face), no sides at all, side counts beyond the maximum, two sides.
      add_item(0, 0); add_item(1, 0); add_item(2, 0); add_item(3, 0);
      add_item(4, 1); add_item(63, 1);
      add_cfg(CSR_RADIUS, 65535); add_cfg(CSR_SIDES, 64);
      add_item(0, 0); add_item(16, 0); add_item(42, 0); add_item(63, 0);
      add_cfg(CSR_SIDES, 1);
      add_item(0, 0); add_item(1, 1);
      add_cfg(CSR_SIDES, 0);
      add_item(0, 1); add_item(21, 1);
      add_cfg(CSR_SIDES, 127);
      add_item(63, 0); add_item(0, 0);
      add_cfg(CSR_RADIUS, 0); add_cfg(CSR_SIDES, 3);
      add_item(1, 0); add_item(2, 0); add_item(3, 1);
      add_cfg(CSR_RADIUS, 100); add_cfg(CSR_SIDES, 2);
      add_item(0, 0); add_item(1, 0); add_item(2, 1);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CFG)
            write_register(stim_rows[i].reg_sel, stim_rows[i].value);
         else
            send_vertex(IDX_W'(stim_rows[i].value), stim_rows[i].typed_in,
                        stim_rows[i].result);
      end

      radii = '{65535, 256, 1, 0, 40000, 12345, 777, 65535, 0, 3000};
      sides = '{64, 5, 3, 7, 127, 1, 0, 3, 64, 2};
      for (int ph = 0; ph < 10; ph++) begin
         if (ph == 4) begin
            send_idle = 77;
            recv_idle = 36;
         end else if (ph == 7) begin
            send_idle = 0;
            recv_idle = 0;
         end
         write_register(CSR_RADIUS, (ph == 9) ? $urandom_range(65535) : radii[ph]);
         write_register(CSR_SIDES, (ph == 9) ? $urandom_range(3, 64) : sides[ph]);
         n = (cur_sides > MAX_SIDES) ? MAX_SIDES : cur_sides;
         for (int j = 0; j < 125; j++) begin
            // Mostly indices within the polygon, the rest anywhere in the field.
            if (n > 0 && $urandom_range(99) < 85) idx = $urandom_range(n - 1);
            else idx = $urandom_range(63);
            send_vertex(IDX_W'(idx), 1'b0, '0);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_vertices.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d vertex words across many radius and side count settings,",
               words_in);
      $display("%0d results checked, %0d of them index errors; %0d mismatches.",
               words_out, error_words, mismatches);
      if (mismatches == 0 && pending_vertices.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
